@@ design/jsu_pkg.sv @@
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Phase codes, result kinds, channel payload types, hex and UTF-8 helpers.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int MaxRes = 8;
  localparam int CntW   = $clog2(MaxRes + 1);
  localparam int PtrW   = $clog2(MaxRes);

  localparam logic [15:0] SURR_HIGH_MIN = 16'hD800;
  localparam logic [15:0] SURR_HIGH_MAX = 16'hDBFF;
  localparam logic [15:0] SURR_LOW_MIN  = 16'hDC00;
  localparam logic [15:0] SURR_LOW_MAX  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE     = 21'h10000;
  localparam logic [20:0] REPL_CHAR     = 21'h0FFFD;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_U = 8'h75;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_TEXT     = 4'd1,
    PH_ESC      = 4'd2,
    PH_HEX      = 4'd3,
    PH_PAIR_BS  = 4'd4,
    PH_PAIR_U   = 4'd5,
    PH_PAIR_HEX = 4'd6,
    PH_DONE     = 4'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_CLOSED = 2'd1,
    KIND_BADHEX = 2'd2,
    KIND_OPEN   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first;
    logic       final_req;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       run_end;
  } out_item_t;

  // Encoded byte run: up to four bytes, b[0] goes out first.
  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] b;
  } utf8_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.val = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t u;
    u = '0;
    if (cp < 21'h80) begin
      u.len  = 3'd1;
      u.b[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h800) begin
      u.len  = 3'd2;
      u.b[0] = {3'b110, cp[10:6]};
      u.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      u.len  = 3'd3;
      u.b[0] = {4'b1110, cp[15:12]};
      u.b[1] = {2'b10, cp[11:6]};
      u.b[2] = {2'b10, cp[5:0]};
    end else begin
      u.len  = 3'd4;
      u.b[0] = {5'b11110, cp[20:18]};
      u.b[1] = {2'b10, cp[17:12]};
      u.b[2] = {2'b10, cp[11:6]};
      u.b[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

  function automatic utf8_t raw_byte(input logic [7:0] c);
    utf8_t u;
    u      = '0;
    u.len  = 3'd1;
    u.b[0] = c;
    return u;
  endfunction

endpackage

@@ design/jsu_in_if.sv @@
// ----------------------------------------------------------------------------
// jsu_in_if: input byte channel
// Valid/ready channel carrying one raw string-body byte and its flags.
// ----------------------------------------------------------------------------
interface jsu_in_if;
  import jsu_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/jsu_out_if.sv @@
// ----------------------------------------------------------------------------
// jsu_out_if: result channel
// Valid/ready channel carrying one decoded byte or status result.
// ----------------------------------------------------------------------------
interface jsu_out_if;
  import jsu_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/json_string_unescape_utf8.sv @@
// ----------------------------------------------------------------------------
// json_string_unescape_utf8: JSON string body unescaper with UTF-8 output
// Decodes backslash escapes and \uXXXX (with surrogate pairs) into UTF-8,
// and reports closed, bad-hex and unterminated status results.
// ----------------------------------------------------------------------------
//  channel   dir  payload                        transfer
//  in_ch     in   in_byte[8] first final_req     valid & ready
//  out_ch    out  out_byte[8] kind[2] run_end    valid & ready
//
//  One input byte per cycle is decoded, while the result buffer is free,
//  from a one-entry input register into a result buffer of up to eight
//  entries, drained one result per cycle while out_ch is ready. Bytes
//  giving one result or none sustain one byte per cycle; others hold the
//  buffer until drained; an empty input register takes bytes meanwhile.
//  rst_n (synchronous, low) returns the decoder to idle and empties both.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
  input  logic      clk,
  input  logic      rst_n,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);
  import jsu_pkg::*;

  localparam logic [7:0] FFFD_B0 = 8'hEF;
  localparam logic [7:0] FFFD_B1 = 8'hBF;
  localparam logic [7:0] FFFD_B2 = 8'hBD;

  // input register
  logic     in_v_r;
  in_item_t in_r;

  // decoder state
  phase_t      phase_r, phase_nxt;
  logic [2:0]  hc_r, hc_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [9:0]  hh_r, hh_nxt;

  // result buffer
  logic                      buf_v_r, buf_v_nxt;
  logic [CntW-1:0]           cnt_r, cnt_nxt;
  logic [PtrW-1:0]           ptr_r;
  logic [MaxRes-1:0][7:0]    rb_r, rb_nxt;
  kind_t [MaxRes-1:0]        rk_r, rk_nxt;

  logic last, buf_free, load;

  assign last     = ({1'b0, ptr_r} == cnt_r - CntW'(1));
  assign buf_free = !buf_v_r || (out_ch.ready && last);
  assign load     = in_v_r && buf_free;
  assign in_ch.ready = !in_v_r || buf_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_v_r <= 1'b1;
    end else if (load) begin
      in_v_r <= 1'b0;
    end
    if (in_ch.valid && in_ch.ready) begin
      in_r <= in_ch.data;
    end
  end

  // ---------------- decode ----------------
  phase_t      ph;
  logic [2:0]  hc;
  logic [15:0] acc, acc_n;
  logic [9:0]  hh;
  logic [7:0]  c;
  hex_t        hx;

  // text byte
  phase_t t_ph;
  utf8_t  t_mn;
  logic   t_close;
  // escaped byte
  phase_t e_ph;
  utf8_t  e_mn;
  // completed \u value
  phase_t f_ph;
  utf8_t  f_mn;
  logic   f_high, is_low;
  logic [20:0] pair_cp;

  logic   pre;
  utf8_t  mn;
  logic   term_en;
  kind_t  term_kind;

  always_comb begin
    c   = in_r.in_byte;
    ph  = in_r.first ? PH_TEXT : phase_r;
    hc  = in_r.first ? 3'd0 : hc_r;
    acc = in_r.first ? 16'd0 : acc_r;
    hh  = in_r.first ? 10'd0 : hh_r;
    hx  = hex_decode(c);
    acc_n = {acc[11:0], hx.val};

    t_ph = PH_TEXT;
    t_mn = '0;
    t_close = 1'b0;
    if (c == CH_QUOTE) begin
      t_close = 1'b1;
      t_ph    = PH_DONE;
    end else if (c == CH_BSLASH) begin
      t_ph = PH_ESC;
    end else begin
      t_mn = raw_byte(c);
    end

    e_ph = PH_TEXT;
    case (c)
      CH_N:    e_mn = raw_byte(8'h0A);
      CH_T:    e_mn = raw_byte(8'h09);
      CH_R:    e_mn = raw_byte(8'h0D);
      CH_B:    e_mn = raw_byte(8'h08);
      CH_F:    e_mn = raw_byte(8'h0C);
      CH_U: begin
        e_mn = '0;
        e_ph = PH_HEX;
      end
      default: e_mn = raw_byte(c);
    endcase

    is_low  = (acc_n >= SURR_LOW_MIN) && (acc_n <= SURR_LOW_MAX);
    f_high  = (acc_n >= SURR_HIGH_MIN) && (acc_n <= SURR_HIGH_MAX);
    pair_cp = SUPP_BASE + {1'b0, hh, acc_n[9:0]};
    if (f_high) begin
      f_ph = PH_PAIR_BS;
      f_mn = '0;
    end else if (is_low) begin
      f_ph = PH_TEXT;
      f_mn = utf8_encode(REPL_CHAR);
    end else begin
      f_ph = PH_TEXT;
      f_mn = utf8_encode({5'd0, acc_n});
    end

    phase_nxt = ph;
    hc_nxt    = hc;
    acc_nxt   = acc;
    hh_nxt    = hh;
    pre       = 1'b0;
    mn        = '0;
    term_en   = 1'b0;
    term_kind = KIND_DATA;

    case (ph)
      PH_TEXT: begin
        phase_nxt = t_ph;
        mn        = t_mn;
        term_en   = t_close;
        term_kind = KIND_CLOSED;
      end
      PH_ESC: begin
        phase_nxt = e_ph;
        mn        = e_mn;
        if (e_ph == PH_HEX) begin
          hc_nxt  = 3'd0;
          acc_nxt = 16'd0;
        end
      end
      PH_HEX, PH_PAIR_HEX: begin
        if (!hx.ok) begin
          term_en   = 1'b1;
          term_kind = KIND_BADHEX;
          phase_nxt = PH_DONE;
        end else begin
          acc_nxt = acc_n;
          hc_nxt  = hc + 3'd1;
          if (hc == 3'd3) begin
            if (ph == PH_PAIR_HEX && is_low) begin
              mn        = utf8_encode(pair_cp);
              phase_nxt = PH_TEXT;
            end else begin
              // plain \u value, or a lone high surrogate before a non-low value
              pre       = (ph == PH_PAIR_HEX);
              mn        = f_mn;
              phase_nxt = f_ph;
              if (f_high) hh_nxt = acc_n[9:0];
            end
          end
        end
      end
      PH_PAIR_BS: begin
        if (c == CH_BSLASH) begin
          phase_nxt = PH_PAIR_U;
        end else begin
          pre       = 1'b1;
          phase_nxt = t_ph;
          mn        = t_mn;
          term_en   = t_close;
          term_kind = KIND_CLOSED;
        end
      end
      PH_PAIR_U: begin
        if (c == CH_U) begin
          phase_nxt = PH_PAIR_HEX;
          hc_nxt    = 3'd0;
          acc_nxt   = 16'd0;
        end else begin
          pre       = 1'b1;
          phase_nxt = e_ph;
          mn        = e_mn;
          if (e_ph == PH_HEX) begin
            hc_nxt  = 3'd0;
            acc_nxt = 16'd0;
          end
        end
      end
      default: ;
    endcase

    if (in_r.final_req && phase_nxt != PH_IDLE && phase_nxt != PH_DONE) begin
      term_en   = 1'b1;
      term_kind = KIND_OPEN;
      phase_nxt = PH_DONE;
    end
  end

  // ---------------- result assembly ----------------
  logic [CntW-1:0] pre_n, main_end;

  always_comb begin
    logic [CntW-1:0] pos, rel;
    pre_n    = pre ? CntW'(3) : CntW'(0);
    main_end = pre_n + CntW'(mn.len);
    cnt_nxt  = main_end + CntW'(term_en);
    for (int i = 0; i < MaxRes; i++) begin
      pos = CntW'(i);
      rel = pos - pre_n;
      rb_nxt[i] = 8'd0;
      rk_nxt[i] = KIND_DATA;
      if (pos < pre_n) begin
        case (pos[1:0])
          2'd0:    rb_nxt[i] = FFFD_B0;
          2'd1:    rb_nxt[i] = FFFD_B1;
          default: rb_nxt[i] = FFFD_B2;
        endcase
      end else if (pos < main_end) begin
        rb_nxt[i] = mn.b[rel[1:0]];
      end else if (pos == main_end && term_en) begin
        rk_nxt[i] = term_kind;
      end
    end
    buf_v_nxt = (cnt_nxt != CntW'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hc_r    <= 3'd0;
      acc_r   <= 16'd0;
      hh_r    <= 10'd0;
      buf_v_r <= 1'b0;
      cnt_r   <= '0;
      ptr_r   <= '0;
    end else if (load) begin
      phase_r <= phase_nxt;
      hc_r    <= hc_nxt;
      acc_r   <= acc_nxt;
      hh_r    <= hh_nxt;
      buf_v_r <= buf_v_nxt;
      cnt_r   <= cnt_nxt;
      ptr_r   <= '0;
    end else if (buf_v_r && out_ch.ready) begin
      if (last) begin
        buf_v_r <= 1'b0;
      end else begin
        ptr_r <= ptr_r + PtrW'(1);
      end
    end
    if (load) begin
      rb_r <= rb_nxt;
      rk_r <= rk_nxt;
    end
  end

  assign out_ch.valid         = buf_v_r;
  assign out_ch.data.out_byte = rb_r[ptr_r];
  assign out_ch.data.kind     = rk_r[ptr_r];
  assign out_ch.data.run_end  = last;

`ifndef SYNTHESIS
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    buf_v_r |-> (cnt_r != '0) && ({1'b0, ptr_r} < cnt_r))
    else $error("result buffer index out of range");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.kind != KIND_DATA) |-> out_ch.data.run_end)
    else $error("status result not last of its run");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.kind != KIND_DATA) |-> (out_ch.data.out_byte == 8'd0))
    else $error("status result carries a nonzero byte");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !last) |=>
      (buf_v_r && ptr_r == $past(ptr_r) + PtrW'(1)))
    else $error("result pointer did not advance");

  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !in_r.first && (phase_r == PH_DONE || phase_r == PH_IDLE)) |-> !buf_v_nxt)
    else $error("stopped decoder produced a result");
`endif

endmodule

@@ tb/sv/json_string_unescape_utf8_test.sv @@
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_test: testbench for the JSON string unescaper
// Drives string bodies through the input channel and checks every decoded
// byte and status result in order against a cycle-free decoder model:
// directed escapes, surrogates and errors, then randomized strings under
// several idle patterns and a long output stall.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_test;
  import jsu_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int MaxReported = 10;

  logic clk;
  logic rst_n;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape_utf8 i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoder model state
  phase_t      ph;
  logic [2:0]  hex_n;
  logic [15:0] acc;
  logic [9:0]  hi10;

  out_item_t   step_q[$];
  out_item_t   decoded_q[$];
  logic [7:0]  txt[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int cycle_cnt;
  int live_items;
  int str_count;
  int results_seen;
  int mismatches;

  // -------------------------------------------------------------------------
  // Decoder model
  // -------------------------------------------------------------------------
  function automatic void push_data(logic [7:0] b);
    out_item_t r;
    r.out_byte = b;
    r.kind     = KIND_DATA;
    r.run_end  = 1'b0;
    step_q.insert(step_q.size(), r);
  endfunction

  function automatic void push_status(kind_t k);
    out_item_t r;
    r.out_byte = 8'h00;
    r.kind     = k;
    r.run_end  = 1'b0;
    step_q.insert(step_q.size(), r);
  endfunction

  function automatic void push_code(int unsigned cp);
    if (cp < 'h80) begin
      push_data(8'(cp));
    end else if (cp < 'h800) begin
      push_data(8'('hC0 | (cp >> 6)));
      push_data(8'('h80 | (cp & 'h3F)));
    end else if (cp < 'h10000) begin
      push_data(8'('hE0 | (cp >> 12)));
      push_data(8'('h80 | ((cp >> 6) & 'h3F)));
      push_data(8'('h80 | (cp & 'h3F)));
    end else begin
      push_data(8'('hF0 | ((cp >> 18) & 'h07)));
      push_data(8'('h80 | ((cp >> 12) & 'h3F)));
      push_data(8'('h80 | ((cp >> 6) & 'h3F)));
      push_data(8'('h80 | (cp & 'h3F)));
    end
  endfunction

  function automatic int hex_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic bit take_hex(logic [7:0] c, output bit bad);
    int v;
    v   = hex_val(c);
    bad = (v < 0);
    if (bad) return 1'b0;
    acc   = {acc[11:0], 4'(v)};
    hex_n = hex_n + 3'd1;
    return hex_n >= 3'd4;
  endfunction

  function automatic void text_char(logic [7:0] c);
    if (c == CH_QUOTE) begin
      push_status(KIND_CLOSED);
      ph = PH_DONE;
    end else if (c == CH_BSLASH) begin
      ph = PH_ESC;
    end else begin
      push_data(c);
    end
  endfunction

  function automatic void esc_char(logic [7:0] c);
    ph = PH_TEXT;
    case (c)
      CH_N: push_data(8'h0A);
      CH_T: push_data(8'h09);
      CH_R: push_data(8'h0D);
      CH_B: push_data(8'h08);
      CH_F: push_data(8'h0C);
      CH_U: begin
        ph    = PH_HEX;
        hex_n = '0;
        acc   = '0;
      end
      default: push_data(c);
    endcase
  endfunction

  // complete \u value that is not a pair's second half
  function automatic void code_done(int unsigned cp);
    if (cp >= SURR_HIGH_MIN && cp <= SURR_HIGH_MAX) begin
      hi10 = 10'(cp - SURR_HIGH_MIN);
      ph   = PH_PAIR_BS;
    end else if (cp >= SURR_LOW_MIN && cp <= SURR_LOW_MAX) begin
      push_code(REPL_CHAR);
      ph = PH_TEXT;
    end else begin
      push_code(cp);
      ph = PH_TEXT;
    end
  endfunction

  function automatic void decode_step(in_item_t it);
    out_item_t   r;
    bit          bad;
    int unsigned lo;
    logic [7:0]  c;
    c = it.in_byte;
    step_q.delete();
    if (it.first || (ph != PH_IDLE && ph != PH_DONE)) live_items++;
    if (it.first) begin
      ph    = PH_TEXT;
      hex_n = '0;
      acc   = '0;
      hi10  = '0;
    end
    case (ph)
      PH_TEXT: text_char(c);
      PH_ESC:  esc_char(c);
      PH_HEX: begin
        if (take_hex(c, bad)) begin
          code_done(acc);
        end else if (bad) begin
          push_status(KIND_BADHEX);
          ph = PH_DONE;
        end
      end
      PH_PAIR_BS: begin
        if (c == CH_BSLASH) begin
          ph = PH_PAIR_U;
        end else begin
          push_code(REPL_CHAR);
          ph = PH_TEXT;
          text_char(c);
        end
      end
      PH_PAIR_U: begin
        if (c == CH_U) begin
          ph    = PH_PAIR_HEX;
          hex_n = '0;
          acc   = '0;
        end else begin
          push_code(REPL_CHAR);
          esc_char(c);
        end
      end
      PH_PAIR_HEX: begin
        if (take_hex(c, bad)) begin
          lo = acc;
          if (lo >= SURR_LOW_MIN && lo <= SURR_LOW_MAX) begin
            push_code(SUPP_BASE + (int'(hi10) << 10) + (lo - SURR_LOW_MIN));
            ph = PH_TEXT;
          end else begin
            push_code(REPL_CHAR);
            code_done(lo);
          end
        end else if (bad) begin
          push_status(KIND_BADHEX);
          ph = PH_DONE;
        end
      end
      default: ;
    endcase
    if (it.final_req && ph != PH_IDLE && ph != PH_DONE) begin
      push_status(KIND_OPEN);
      ph = PH_DONE;
    end
    if (step_q.size() > 0) begin
      r = step_q[step_q.size() - 1];
      r.run_end = 1'b1;
      step_q[step_q.size() - 1] = r;
    end
    foreach (step_q[i]) decoded_q.insert(decoded_q.size(), step_q[i]);
  endfunction

  function automatic void check_result(out_item_t got);
    out_item_t want;
    results_seen++;
    if (decoded_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxReported)
        $display("ERROR: unexpected result byte %h kind %0d end %b",
                 got.out_byte, got.kind, got.run_end);
      return;
    end
    want = decoded_q.pop_front();
    if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
        got.run_end !== want.run_end) begin
      mismatches++;
      if (mismatches <= MaxReported)
        $display("ERROR: result %0d expected byte %h kind %0d end %b, got %h %0d %b",
                 results_seen, want.out_byte, want.kind, want.run_end,
                 got.out_byte, got.kind, got.run_end);
    end
  endfunction

  // Both channels sampled at the rising edge, input first
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) decode_step(in_ch.data);
      if (out_ch.valid && out_ch.ready) check_result(out_ch.data);
    end
  end

  // Result consumer: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("ERROR: timeout after %0d cycles, %0d results pending",
             cycle_cnt, decoded_q.size());
    $display("Verification failed");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  task automatic send_item(logic [7:0] b, bit fst, bit fin);
    in_item_t it;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    it.in_byte   = b;
    it.first     = fst;
    it.final_req = fin;
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_text(bit fin_last);
    foreach (txt[i]) send_item(txt[i], i == 0, fin_last && i == txt.size() - 1);
    str_count++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic void txt_add(logic [7:0] c);
    txt.insert(txt.size(), c);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'("0" + n);
    return 8'(($urandom_range(1) ? "A" : "a") + n - 10);
  endfunction

  function automatic logic [7:0] bad_hex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (hex_val(c) >= 0);
    return c;
  endfunction

  function automatic void put_u(logic [15:0] v);
    txt_add(CH_BSLASH);
    txt_add(CH_U);
    for (int i = 3; i >= 0; i--) txt_add(hex_char(v[i*4 +: 4]));
  endfunction

  function automatic logic [15:0] rand_high();
    return 16'(SURR_HIGH_MIN + $urandom_range(16'h3FF));
  endfunction

  function automatic void put_piece();
    logic [7:0]  c;
    logic [15:0] v;
    case ($urandom_range(15))
      0, 1, 2, 3, 4: begin
        c = 8'($urandom_range(255));
        if (c == CH_QUOTE || c == CH_BSLASH) c = 8'($urandom_range(8'h41, 8'h5A));
        txt_add(c);
      end
      5: begin
        txt_add(CH_BSLASH);
        case ($urandom_range(4))
          0: txt_add(CH_N);
          1: txt_add(CH_T);
          2: txt_add(CH_R);
          3: txt_add(CH_B);
          default: txt_add(CH_F);
        endcase
      end
      6: begin
        c = 8'($urandom_range(255));
        if (c == CH_U) c = CH_BSLASH;
        txt_add(CH_BSLASH);
        txt_add(c);
      end
      7, 8: put_u(16'($urandom_range(16'hFFFF)));
      9, 10: begin
        put_u(rand_high());
        put_u(16'(SURR_LOW_MIN + $urandom_range(16'h3FF)));
      end
      11: put_u(16'(SURR_LOW_MIN + $urandom_range(16'h3FF)));
      12: put_u(rand_high());
      13: begin
        // high half followed by a \u value that cannot complete the pair
        v = 16'($urandom_range(16'hFFFF));
        if (v >= SURR_LOW_MIN && v <= SURR_LOW_MAX) v = v ^ 16'h2000;
        put_u(rand_high());
        put_u(v);
      end
      14: begin
        c = 8'($urandom_range(255));
        if (c == CH_U) c = CH_N;
        put_u(rand_high());
        txt_add(CH_BSLASH);
        txt_add(c);
      end
      default: begin
        case ($urandom_range(5))
          0: v = 16'h0000;
          1: v = 16'h007F;
          2: v = 16'h0080;
          3: v = 16'h07FF;
          4: v = 16'h0800;
          default: v = 16'hFFFF;
        endcase
        put_u(v);
      end
    endcase
  endfunction

  task automatic send_random_string();
    int  r;
    bit  fin;
    txt.delete();
    repeat ($urandom_range(0, 10)) put_piece();
    r = $urandom_range(99);
    if (r < 75) begin
      txt_add(CH_QUOTE);
      fin = ($urandom_range(3) == 0);
      // trailing bytes after the close are dropped by the block
      if (!fin && $urandom_range(3) == 0)
        repeat ($urandom_range(1, 2)) txt_add(8'($urandom_range(255)));
    end else if (r < 85) begin
      txt_add(CH_BSLASH);
      txt_add(CH_U);
      repeat ($urandom_range(3)) txt_add(hex_char(4'($urandom_range(15))));
      txt_add(bad_hex_char());
      fin = $urandom_range(1);
    end else begin
      // input runs out with the string open
      case ($urandom_range(3))
        0: txt_add(CH_BSLASH);
        1: begin
          txt_add(CH_BSLASH);
          txt_add(CH_U);
          repeat ($urandom_range(3)) txt_add(hex_char(4'($urandom_range(15))));
        end
        2: put_u(rand_high());
        default: if (txt.size() == 0) txt_add(8'($urandom_range(8'h20, 8'h7E)));
      endcase
      fin = 1'b1;
    end
    send_text(fin);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6))
      send_item(8'($urandom_range(255)), $urandom_range(5) == 0, $urandom_range(5) == 0);
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  task automatic test_ignored_bytes();
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(CH_QUOTE, 1'b0, 1'b1);
  endtask

  task automatic test_simple_escapes();
    txt = '{8'h00, CH_BSLASH, CH_T, 8'hFF, CH_BSLASH, 8'h2F, CH_QUOTE, 8'h78};
    send_text(1'b0);
  endtask

  task automatic test_surrogate_pair();
    txt.delete();
    put_u(16'hD83D);
    put_u(16'hDE00);
    txt_add(CH_QUOTE);
    send_text(1'b1);
  endtask

  task automatic test_bad_hex();
    txt = '{CH_BSLASH, CH_U, 8'h30, 8'h67};
    send_text(1'b0);
  endtask

  task automatic test_random(int sidle, int ridle, int goal);
    int r;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    while (live_items < goal) begin
      r = $urandom_range(99);
      if (r < 85) send_random_string();
      else send_noise();
    end
    wait_drained();
  endtask

  // output held off while the sender keeps pushing multi-byte expansions
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 300;
    repeat (2) begin
      txt.delete();
      repeat (3) begin
        put_u(rand_high());
        put_u(16'(SURR_LOW_MIN + $urandom_range(16'h3FF)));
      end
      put_u(16'hFFFF);
      txt_add(CH_QUOTE);
      send_text(1'b0);
    end
    wait_drained();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    out_ch.ready  = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 0;
    live_items    = 0;
    str_count     = 0;
    results_seen  = 0;
    mismatches    = 0;
    ph            = PH_IDLE;
    hex_n         = '0;
    acc           = '0;
    hi10          = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 17;
    recv_idle_pct = 50;
    test_ignored_bytes();
    test_simple_escapes();
    test_surrogate_pair();
    test_bad_hex();
    wait_drained();

    test_random(17, 50, live_items + 70);
    test_random(50, 17, live_items + 70);
    test_random(0, 0, live_items + 70);
    test_backpressure();

    $display("Covered %0d strings, %0d decoded input bytes, %0d results checked",
             str_count, live_items, results_seen);
    $display("Escapes, surrogate pairs, lone surrogates, bad hex, open strings, stalls");
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatches, decoded_q.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
